// ----- hdl/sbgr_pkg.sv -----
// Shared types and constants for the semaphore bank with group rollback.
package sbgr_pkg;

    localparam int VAL_W = 15;
    localparam int IDX_W = 5;
    localparam int REQ_W = 16;
    localparam int CFG_W = 6;

    localparam logic [CFG_W-1:0] CFG_RESET = 6'd32;
    localparam logic [VAL_W-1:0] VAL_RESET = 15'd1;
    localparam logic [REQ_W-1:0] REQ_RESET = 16'd0;

    localparam logic [1:0] ACT_DELTA = 2'd0;
    localparam logic [1:0] ACT_SET   = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_RANGE      = 3'd1;
    localparam logic [2:0] ST_AGAIN      = 3'd2;
    localparam logic [2:0] ST_BLOCK      = 3'd3;
    localparam logic [2:0] ST_TOO_LONG   = 3'd4;
    localparam logic [2:0] ST_BAD_ACTION = 3'd5;
    localparam logic [2:0] ST_ABORTED    = 3'd6;

    typedef struct packed {
        logic [1:0]        action;
        logic [IDX_W-1:0]  sem_index;
        logic signed [15:0] delta;
        logic signed [15:0] set_value;
        logic              no_wait;
        logic              group_last;
        logic [REQ_W-1:0]  requester_id;
    } cmd_t;

    typedef struct packed {
        logic [2:0]       status;
        logic [VAL_W-1:0] value;
        logic             is_zero;
        logic [REQ_W-1:0] last_requester;
        logic             rolled_back;
    } result_t;

    // Classified operation as it sits in the queue
    typedef struct packed {
        logic [1:0]         action;
        logic [2:0]         pre_status;
        logic [IDX_W-1:0]   sem_index;
        logic signed [15:0] delta;
        logic [VAL_W-1:0]   set_value;
        logic               no_wait;
        logic               group_last;
        logic [REQ_W-1:0]   requester_id;
    } op_t;

endpackage

// ----- hdl/sbgr_front.sv -----
// Front end: command intake, config register and stateless checks.
module sbgr_front
    import sbgr_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int MAX_VALUE = 32767
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  cmd_t             cmd,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    input  logic             full,
    output logic             busy,
    output logic             push,
    output op_t              push_op
);

    logic [CFG_W-1:0] sems_in_use_reg;
    logic             idx_bad;
    logic             set_bad;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sems_in_use_reg <= CFG_RESET;
        end
        else if (cfg_we)
        begin
            sems_in_use_reg <= cfg_data;
        end
    end

    assign busy = full;
    assign push = start && !full;

    always_comb
    begin
        idx_bad = ({1'b0, cmd.sem_index} >= sems_in_use_reg) ||
                  (32'(cmd.sem_index) >= NUM_SEMS);
        set_bad = cmd.set_value[15] || ($unsigned(cmd.set_value) > 16'(MAX_VALUE));

        push_op.action       = cmd.action;
        push_op.sem_index    = cmd.sem_index;
        push_op.delta        = cmd.delta;
        push_op.set_value    = cmd.set_value[VAL_W-1:0];
        push_op.no_wait      = cmd.no_wait;
        push_op.group_last   = cmd.group_last;
        push_op.requester_id = cmd.requester_id;

        // precedence among the stateless checks: action, index, set value
        unique case (cmd.action) inside
            ACT_DELTA, ACT_READ:
            begin
                push_op.pre_status = idx_bad ? ST_RANGE : ST_OK;
            end
            ACT_SET:
            begin
                push_op.pre_status = (idx_bad || set_bad) ? ST_RANGE : ST_OK;
            end
            default:
            begin
                push_op.pre_status = ST_BAD_ACTION;
            end
        endcase
    end

endmodule

// ----- hdl/sbgr_queue.sv -----
// Two-entry queue of classified operations between front and back.
module sbgr_queue
    import sbgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    input  logic pop,
    output op_t  head,
    output logic empty,
    output logic full
);

    op_t        slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] cnt_reg;

    assign empty = (cnt_reg == 2'd0);
    assign full  = (cnt_reg == 2'd2);
    assign head  = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   cnt_reg <= cnt_reg + 2'd1;
                2'b01:   cnt_reg <= cnt_reg - 2'd1;
                default: cnt_reg <= cnt_reg;
            endcase
        end
    end

endmodule

// ----- hdl/sbgr_back.sv -----
// Back end: semaphore RAM read-modify-write, group journal and rollback walk.
module sbgr_back
    import sbgr_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int MAX_VALUE = 32767,
    parameter int MAX_GROUP = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  op_t     head,
    output logic    pop,
    output logic    done,
    output result_t result
);

    localparam int SEM_DEPTH = (NUM_SEMS < 32) ? NUM_SEMS : 32;
    localparam int SEM_AW    = (SEM_DEPTH > 1) ? $clog2(SEM_DEPTH) : 1;
    localparam int GL_W      = $clog2(MAX_GROUP + 1);
    localparam int JA_W      = (MAX_GROUP > 1) ? $clog2(MAX_GROUP) : 1;
    localparam logic signed [16:0] MAX_S = 17'(MAX_VALUE);
    localparam logic signed [16:0] MIN_S = -17'(MAX_VALUE);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_EXEC  = 5'b00010,
        S_RB_RD = 5'b00100,
        S_RB_WR = 5'b01000,
        S_SPARE = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // storage
    logic [VAL_W-1:0]  sem_mem [SEM_DEPTH];
    logic [REQ_W-1:0]  id_mem  [SEM_DEPTH];
    logic [SEM_DEPTH-1:0] val_ok_reg;
    logic [SEM_DEPTH-1:0] id_ok_reg;
    logic [SEM_AW-1:0] jnl_idx_mem [MAX_GROUP];
    logic [VAL_W-1:0]  jnl_old_mem [MAX_GROUP];

    // read data
    logic [VAL_W-1:0]  rd_val_reg;
    logic              rd_vok_reg;
    logic [REQ_W-1:0]  rd_id_reg;
    logic              rd_iok_reg;
    logic [SEM_AW-1:0] jnl_idx_rd_reg;
    logic [VAL_W-1:0]  jnl_old_rd_reg;

    op_t               cur_reg;
    logic [GL_W-1:0]   glen_reg, glen_next;
    logic              failed_reg, failed_next;
    logic [2:0]        pend_reg, pend_next;
    result_t           res_reg, res_next;
    logic              done_reg, done_next;

    logic [SEM_AW-1:0] raddr;
    logic [SEM_AW-1:0] cur_addr;
    logic [VAL_W-1:0]  old_val;
    logic [REQ_W-1:0]  old_id;
    logic signed [16:0] nv;
    logic [2:0]        ex_status;
    logic [VAL_W-1:0]  new_val;
    logic [REQ_W-1:0]  new_id;
    logic [GL_W-1:0]   glen_dec;
    logic              too_long;

    logic              sem_we;
    logic [SEM_AW-1:0] sem_waddr;
    logic [VAL_W-1:0]  sem_wdata;
    logic              id_we;
    logic              jnl_we;
    logic              jnl_re;

    assign raddr    = head.sem_index[SEM_AW-1:0];
    assign cur_addr = cur_reg.sem_index[SEM_AW-1:0];
    assign old_val  = rd_vok_reg ? rd_val_reg : VAL_RESET;
    assign old_id   = rd_iok_reg ? rd_id_reg : REQ_RESET;
    assign glen_dec = glen_reg - GL_W'(1);
    assign too_long = (32'(glen_reg) >= MAX_GROUP);
    assign nv       = $signed({2'b00, old_val}) + $signed({cur_reg.delta[15], cur_reg.delta});

    assign done   = done_reg;
    assign result = res_reg;

    // status of the item in execute, abort aside
    always_comb
    begin
        if (too_long)
        begin
            ex_status = ST_TOO_LONG;
        end
        else if (cur_reg.pre_status != ST_OK)
        begin
            ex_status = cur_reg.pre_status;
        end
        else if (cur_reg.action == ACT_DELTA)
        begin
            if (nv > MAX_S || nv < MIN_S)
            begin
                ex_status = ST_RANGE;
            end
            else if (nv < 0)
            begin
                ex_status = cur_reg.no_wait ? ST_AGAIN : ST_BLOCK;
            end
            else
            begin
                ex_status = ST_OK;
            end
        end
        else
        begin
            ex_status = ST_OK;
        end

        case (cur_reg.action)
            ACT_DELTA: new_val = nv[VAL_W-1:0];
            ACT_SET:   new_val = cur_reg.set_value;
            default:   new_val = old_val;
        endcase
        new_id = (cur_reg.action == ACT_DELTA) ? cur_reg.requester_id : old_id;
    end

    always_comb
    begin
        state_next = state_reg;
        glen_next  = glen_reg;
        failed_next = failed_reg;
        pend_next  = pend_reg;
        res_next   = res_reg;
        done_next  = 1'b0;
        pop        = 1'b0;
        sem_we     = 1'b0;
        sem_waddr  = cur_addr;
        sem_wdata  = new_val;
        id_we      = 1'b0;
        jnl_we     = 1'b0;
        jnl_re     = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    pop        = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
                res_next   = '0;
                if (failed_reg)
                begin
                    res_next.status = ST_ABORTED;
                    done_next       = 1'b1;
                    if (cur_reg.group_last)
                    begin
                        failed_next = 1'b0;
                    end
                end
                else if (ex_status == ST_OK)
                begin
                    sem_we = (cur_reg.action == ACT_DELTA) || (cur_reg.action == ACT_SET);
                    id_we  = (cur_reg.action == ACT_DELTA);
                    res_next.status         = ST_OK;
                    res_next.value          = new_val;
                    res_next.is_zero        = (new_val == '0);
                    res_next.last_requester = new_id;
                    done_next               = 1'b1;
                    if (cur_reg.group_last)
                    begin
                        glen_next = '0;
                    end
                    else
                    begin
                        jnl_we    = 1'b1;
                        glen_next = glen_reg + GL_W'(1);
                    end
                end
                else
                begin
                    failed_next = !cur_reg.group_last;
                    pend_next   = ex_status;
                    if (glen_reg != '0)
                    begin
                        state_next = S_RB_RD;
                    end
                    else
                    begin
                        res_next.status = ex_status;
                        done_next       = 1'b1;
                    end
                end
            end
            S_RB_RD:
            begin
                // newest journal entry first
                jnl_re     = 1'b1;
                glen_next  = glen_dec;
                state_next = S_RB_WR;
            end
            S_RB_WR:
            begin
                sem_we    = 1'b1;
                sem_waddr = jnl_idx_rd_reg;
                sem_wdata = jnl_old_rd_reg;
                if (glen_reg == '0)
                begin
                    res_next             = '0;
                    res_next.status      = pend_reg;
                    res_next.rolled_back = 1'b1;
                    done_next            = 1'b1;
                    state_next           = S_IDLE;
                end
                else
                begin
                    state_next = S_RB_RD;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (sem_we)
        begin
            sem_mem[sem_waddr] <= sem_wdata;
        end
        if (id_we)
        begin
            id_mem[sem_waddr] <= cur_reg.requester_id;
        end
        if (pop)
        begin
            rd_val_reg <= sem_mem[raddr];
            rd_vok_reg <= val_ok_reg[raddr];
            rd_id_reg  <= id_mem[raddr];
            rd_iok_reg <= id_ok_reg[raddr];
            cur_reg    <= head;
        end
        if (jnl_we)
        begin
            jnl_idx_mem[glen_reg[JA_W-1:0]] <= cur_addr;
            jnl_old_mem[glen_reg[JA_W-1:0]] <= old_val;
        end
        if (jnl_re)
        begin
            jnl_idx_rd_reg <= jnl_idx_mem[glen_dec[JA_W-1:0]];
            jnl_old_rd_reg <= jnl_old_mem[glen_dec[JA_W-1:0]];
        end
        pend_reg <= pend_next;
        res_reg  <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            glen_reg   <= '0;
            failed_reg <= 1'b0;
            done_reg   <= 1'b0;
            val_ok_reg <= '0;
            id_ok_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            glen_reg   <= glen_next;
            failed_reg <= failed_next;
            done_reg   <= done_next;
            if (sem_we)
            begin
                val_ok_reg[sem_waddr] <= 1'b1;
            end
            if (id_we)
            begin
                id_ok_reg[sem_waddr] <= 1'b1;
            end
        end
    end

endmodule

// ----- hdl/semaphore_bank_with_group_rollback.sv -----
// Top level of the semaphore bank with group rollback.
//
//   channel   handshake             payload        direction
//   command   start / busy          cmd (cmd_t)    in
//   result    done (one cycle)      result         out
//   config    cfg_we                cfg_data       in
//
// A normal beat in the back end is a semaphore RAM read (S_IDLE pop), then the update (S_EXEC).
// A failure after k journaled group items walks the journal, an S_RB_RD read and an S_RB_WR restore per item.
// Up to two beats queue between front and back; busy is high while the queue is full.
// Reset is immediate: per-entry valid bits stand in for the initial semaphore values.
// Results cannot be held off by the receiver.
module semaphore_bank_with_group_rollback
    import sbgr_pkg::*;
#(
    parameter int NUM_SEMS  = 32,
    parameter int MAX_VALUE = 32767,
    parameter int MAX_GROUP = 16
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cmd_t             cmd,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             done,
    output result_t          result
);

    logic push;
    op_t  push_op;
    logic pop;
    op_t  head;
    logic empty;
    logic full;

    sbgr_front #(
        .NUM_SEMS  (NUM_SEMS),
        .MAX_VALUE (MAX_VALUE)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .full     (full),
        .busy     (busy),
        .push     (push),
        .push_op  (push_op)
    );

    sbgr_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    sbgr_back #(
        .NUM_SEMS  (NUM_SEMS),
        .MAX_VALUE (MAX_VALUE),
        .MAX_GROUP (MAX_GROUP)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// ----- dv/tb_semaphore_bank_with_group_rollback.sv -----
// Self-checking testbench for the semaphore bank with group rollback.
module tb_semaphore_bank_with_group_rollback;
    import sbgr_pkg::*;

    localparam int NUM_SEMS  = 32;
    localparam int MAX_VALUE = 32767;
    localparam int MAX_GROUP = 16;
    localparam logic [1:0] ACT_UNDEF = 2'd3;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    cmd_t             cmd = '0;
    logic             cfg_we = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             done;
    result_t          result;

    semaphore_bank_with_group_rollback DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .cmd      (cmd),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .done     (done),
        .result   (result)
    );

    cmd_t    cmds_to_send[$];
    result_t replies_due[$];
    int      gap_pct = 0;

    // shadow copy of the bank
    logic [CFG_W-1:0] bank_size;
    logic [VAL_W-1:0] sem_val [NUM_SEMS];
    logic [REQ_W-1:0] sem_owner [NUM_SEMS];
    logic [IDX_W-1:0] jrnl_idx [MAX_GROUP];
    logic [VAL_W-1:0] jrnl_old [MAX_GROUP];
    int               grp_len;
    logic             grp_failed;

    int mismatches = 0;
    int cmds_accepted = 0;
    int replies_seen = 0;
    int rollbacks_seen = 0;
    int status_seen [8];

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("semaphore_bank_with_group_rollback verification failed");
        $finish;
    end

    function automatic result_t apply_sem_op(cmd_t c);
        result_t          r;
        logic [2:0]       st;
        logic [VAL_W-1:0] old_val;
        int               lim;
        int               nv;
        int               sv;
        r = '0;
        st = ST_OK;
        old_val = '0;
        lim = (int'(bank_size) < NUM_SEMS) ? int'(bank_size) : NUM_SEMS;
        if (grp_failed)
        begin
            r.status = ST_ABORTED;
            if (c.group_last)
                grp_failed = 1'b0;
            return r;
        end
        if (grp_len >= MAX_GROUP)
            st = ST_TOO_LONG;
        else if (c.action == ACT_UNDEF)
            st = ST_BAD_ACTION;
        else if (int'(c.sem_index) >= lim)
            st = ST_RANGE;
        else
        begin
            old_val = sem_val[c.sem_index];
            if (c.action == ACT_DELTA)
            begin
                nv = int'(old_val) + int'($signed(c.delta));
                if (nv > MAX_VALUE || nv < -MAX_VALUE)
                    st = ST_RANGE;
                else if (nv < 0)
                    st = c.no_wait ? ST_AGAIN : ST_BLOCK;
                else
                begin
                    sem_val[c.sem_index] = nv[VAL_W-1:0];
                    sem_owner[c.sem_index] = c.requester_id;
                end
            end
            else if (c.action == ACT_SET)
            begin
                sv = int'($signed(c.set_value));
                if (sv < 0 || sv > MAX_VALUE)
                    st = ST_RANGE;
                else
                    sem_val[c.sem_index] = sv[VAL_W-1:0];
            end
        end
        if (st != ST_OK)
        begin
            r.status = st;
            r.rolled_back = (grp_len > 0);
            // undo newest first; owners keep their updates
            while (grp_len > 0)
            begin
                grp_len--;
                sem_val[jrnl_idx[grp_len]] = jrnl_old[grp_len];
            end
            grp_failed = !c.group_last;
            return r;
        end
        r.value = sem_val[c.sem_index];
        r.is_zero = (sem_val[c.sem_index] == '0);
        r.last_requester = sem_owner[c.sem_index];
        if (c.group_last)
            grp_len = 0;
        else
        begin
            jrnl_idx[grp_len] = c.sem_index;
            jrnl_old[grp_len] = old_val;
            grp_len++;
        end
        return r;
    endfunction

    // driver: next beat once the current one is taken
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            cmd <= '0;
        end
        else if (!start || !busy)
        begin
            if (cmds_to_send.size() != 0 && $urandom_range(0, 99) >= gap_pct)
            begin
                start <= 1'b1;
                cmd <= cmds_to_send.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // monitor and predictor
    always @(posedge clk)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            bank_size = CFG_RESET;
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                sem_val[i] = VAL_RESET;
                sem_owner[i] = REQ_RESET;
            end
            grp_len = 0;
            grp_failed = 1'b0;
        end
        else
        begin
            if (done)
            begin
                replies_seen++;
                status_seen[result.status]++;
                if (result.rolled_back)
                    rollbacks_seen++;
                if (replies_due.size() == 0)
                begin
                    if (mismatches < 10)
                        $display("unexpected result beat, status %0d", result.status);
                    mismatches++;
                end
                else
                begin
                    exp_r = replies_due.pop_front();
                    if (result.status !== exp_r.status || result.value !== exp_r.value ||
                        result.is_zero !== exp_r.is_zero ||
                        result.last_requester !== exp_r.last_requester ||
                        result.rolled_back !== exp_r.rolled_back)
                    begin
                        if (mismatches < 10)
                            $display({"result %0d: exp st=%0d val=%0d z=%0b id=%h rb=%0b,",
                                      " got st=%0d val=%0d z=%0b id=%h rb=%0b"},
                                     replies_seen, exp_r.status, exp_r.value,
                                     exp_r.is_zero, exp_r.last_requester,
                                     exp_r.rolled_back, result.status, result.value,
                                     result.is_zero, result.last_requester,
                                     result.rolled_back);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                cmds_accepted++;
                replies_due.push_back(apply_sem_op(cmd));
            end
            if (cfg_we)
                bank_size = cfg_data;
        end
    end

    function automatic cmd_t mk_cmd(logic [1:0] act, int idx, int d, int sv, bit nw,
                                    bit last, int req);
        cmd_t c;
        c.action = act;
        c.sem_index = IDX_W'(idx);
        c.delta = 16'(d);
        c.set_value = 16'(sv);
        c.no_wait = nw;
        c.group_last = last;
        c.requester_id = REQ_W'(req);
        return c;
    endfunction

    // tame commands nearly always succeed, so long groups reach the length cap
    function automatic cmd_t random_cmd(bit last, int lim, bit tame);
        cmd_t c;
        int   r;
        c.requester_id = REQ_W'($urandom);
        c.no_wait = 1'($urandom_range(0, 1));
        c.group_last = last;
        r = $urandom_range(0, 99);
        if (tame)
            c.action = (r < 40) ? ACT_DELTA : (r < 55) ? ACT_SET : ACT_READ;
        else
            c.action = (r < 40) ? ACT_DELTA : (r < 60) ? ACT_SET :
                       (r < 94) ? ACT_READ : ACT_UNDEF;
        if (lim > 0 && (tame || $urandom_range(0, 9) != 0))
            c.sem_index = IDX_W'($urandom_range(0, lim - 1));
        else
            c.sem_index = IDX_W'($urandom_range(0, NUM_SEMS - 1));
        r = $urandom_range(0, 99);
        if (tame)
            c.delta = 16'($urandom_range(0, 3));
        else if (r < 60)
            c.delta = 16'(int'($urandom_range(0, 6)) - 3);
        else if (r < 75)
            c.delta = 16'(int'($urandom_range(0, 2000)) - 1000);
        else if (r < 90)
            c.delta = 16'($urandom);
        else
            c.delta = $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
        r = $urandom_range(0, 99);
        if (tame || r < 60)
            c.set_value = 16'($urandom_range(0, 8));
        else if (r < 85)
            c.set_value = 16'($urandom);
        else
            c.set_value = (r < 90) ? 16'sh7fff : (r < 95) ? 16'sh8000 : 16'shffff;
        return c;
    endfunction

    task automatic fill_random(int n_items, int lim);
        int pushed;
        int glen;
        int r;
        pushed = 0;
        while (pushed < n_items)
        begin
            r = $urandom_range(0, 99);
            glen = (r < 50) ? 1 : (r < 85) ? $urandom_range(2, 6) : $urandom_range(14, 18);
            for (int k = 0; k < glen; k++)
                cmds_to_send.push_back(random_cmd(k == glen - 1, lim, glen >= 14));
            pushed += glen;
        end
    endtask

    // returns at a falling edge with nothing queued or outstanding
    task automatic drain_replies();
        do
            @(negedge clk);
        while (cmds_to_send.size() != 0 || start || replies_due.size() != 0);
    endtask

    task automatic write_bank_size(logic [CFG_W-1:0] v);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] cfg_plan [6];
        int               lim;
        cfg_plan = '{6'd32, 6'd1, 6'd0, 6'd63, 6'd32, 6'd32};
        cfg_plan[4] = CFG_W'($urandom_range(2, 31));
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        for (int ph = 0; ph < 6; ph++)
        begin
            gap_pct = (ph < 2) ? 8 : (ph < 4) ? 48 : 0;
            drain_replies();
            write_bank_size(cfg_plan[ph]);
            @(negedge clk);
            lim = (int'(cfg_plan[ph]) < NUM_SEMS) ? int'(cfg_plan[ph]) : NUM_SEMS;
            if (ph == 0)
            begin
                cmds_to_send.push_back(mk_cmd(ACT_READ, 0, 0, 0, 0, 1, 0));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 0, -1, 0, 0, 1, 'hffff));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 0, -1, 0, 1, 1, 'h1111));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 0, -1, 0, 0, 1, 'h2222));
                // sum below -MAX_VALUE is a range error, not a block
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 0, -32768, 0, 1, 1, 'h3333));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 31, 32767, 0, 0, 1, 'h4444));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 31, 32766, 0, 0, 1, 0));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 31, 0, 0, 0, 1, 'h8000));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 31, -32768, 0, 0, 1, 'h5555));
                cmds_to_send.push_back(mk_cmd(ACT_SET, 2, 0, -32768, 0, 1, 'h6666));
                cmds_to_send.push_back(mk_cmd(ACT_SET, 2, 0, 32767, 0, 1, 'h7777));
                cmds_to_send.push_back(mk_cmd(ACT_SET, 3, 0, 0, 1, 1, 'h8888));
                cmds_to_send.push_back(mk_cmd(ACT_UNDEF, 0, 0, 0, 0, 1, 'h9999));
                // group failing on its fourth beat, then aborted tail
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 4, 5, 0, 0, 0, 'haaaa));
                cmds_to_send.push_back(mk_cmd(ACT_SET, 5, 0, 9, 0, 0, 'hbbbb));
                cmds_to_send.push_back(mk_cmd(ACT_READ, 4, 0, 0, 0, 0, 0));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 5, -100, 0, 1, 0, 'hcccc));
                cmds_to_send.push_back(mk_cmd(ACT_READ, 6, 0, 0, 0, 0, 0));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 6, 1, 0, 0, 1, 'hdddd));
                cmds_to_send.push_back(mk_cmd(ACT_READ, 4, 0, 0, 0, 1, 0));
                // first beat of the group fails: nothing to restore
                cmds_to_send.push_back(mk_cmd(ACT_SET, 7, 0, -1, 0, 0, 0));
                cmds_to_send.push_back(mk_cmd(ACT_READ, 7, 0, 0, 0, 1, 0));
                // last beat of the group fails
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 8, 1, 0, 0, 0, 'heeee));
                cmds_to_send.push_back(mk_cmd(ACT_DELTA, 8, 32767, 0, 0, 1, 'hffff));
                cmds_to_send.push_back(mk_cmd(ACT_READ, 8, 0, 0, 0, 1, 0));
            end
            if (lim < NUM_SEMS)
                cmds_to_send.push_back(mk_cmd(ACT_READ, lim, 0, 0, 0, 1, 0));
            if (lim > 0)
                cmds_to_send.push_back(mk_cmd(ACT_READ, lim - 1, 0, 0, 0, 1, 0));
            if (ph == 1)
            begin
                fill_random(125, lim);
                drain_replies();
                fill_random(125, lim);
            end
            else
                fill_random(250, lim);
        end
        drain_replies();
        repeat (50) @(posedge clk);
        $display("%0d commands over bank sizes 32, 1, 0, 63 and %0d; %0d rollbacks seen",
                 cmds_accepted, cfg_plan[4], rollbacks_seen);
        $display({"status mix: ok %0d range %0d again %0d block %0d too-long %0d",
                  " bad-action %0d aborted %0d"},
                 status_seen[ST_OK], status_seen[ST_RANGE], status_seen[ST_AGAIN],
                 status_seen[ST_BLOCK], status_seen[ST_TOO_LONG],
                 status_seen[ST_BAD_ACTION], status_seen[ST_ABORTED]);
        if (mismatches == 0 && replies_due.size() == 0)
            $display("semaphore_bank_with_group_rollback verification clean");
        else
        begin
            $display("%0d mismatches, %0d results never arrived",
                     mismatches, replies_due.size());
            $display("semaphore_bank_with_group_rollback verification failed");
        end
        $finish;
    end

endmodule
